/* rtl/cubic_spline_evaluator_defines.svh */
// assertion macros shared by the cubic spline evaluator checkers
`ifndef CUBIC_SPLINE_EVALUATOR_DEFINES_SVH
`define CUBIC_SPLINE_EVALUATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CSEV_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("csev check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define CSEV_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("csev check failed");

`endif

/* rtl/csev_pkg.sv */
// shared constants, command codes and queue entry type of the spline evaluator
`default_nettype none
package csev_pkg;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_KNOTS   = 64;
	localparam int KNOT_AW     = $clog2(MAX_KNOTS);
	localparam int COEF_DEPTH  = 4 * MAX_KNOTS;
	localparam int COEF_AW     = $clog2(COEF_DEPTH);
	localparam int CNT_W       = 7;
	localparam int SEG_W       = 6;
	localparam int IDX_W       = 8;
	localparam int DATA_W      = 32;
	localparam int ACC_W       = 128;
	localparam int LIMB_W      = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_LOAD_KNOT = 2'd0,
		CMD_LOAD_COEF = 2'd1,
		CMD_EVAL      = 2'd2
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] d;
		logic signed [DATA_W-1:0] c;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] a;
		logic [KNOT_AW-1:0]       seg;
	} job_t;
endpackage
`default_nettype wire

/* rtl/csev_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module csev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* rtl/csev_front.sv */
// front end: accepts commands, writes tables, searches knots, fetches coefficients
`default_nettype none
module csev_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [csev_pkg::IDX_W-1:0]  index,
	input  logic signed [csev_pkg::DATA_W-1:0] value,
	input  logic [csev_pkg::CNT_W-1:0]  knot_count,
	input  logic                        q_full,
	output logic                        q_push,
	output csev_pkg::job_t              q_job
);
	import csev_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_SEARCH, F_FETCH, F_PUSH} fstate_t;

	fstate_t                  state_q;
	logic [KNOT_AW-1:0]       lo_q, hi_q, mid_q, seg_q;
	logic signed [DATA_W-1:0] x_q;
	logic [2:0]               fcnt_q;
	job_t                     job_q;

	logic                     accept;
	logic [CNT_W-1:0]         n_c;
	logic [KNOT_AW-1:0]       hi0, mid0, lo_n, hi_n, mid_n, diff_n;
	logic                     more0, more_n, knot_gt;
	logic                     knot_we, coef_we;
	logic [KNOT_AW-1:0]       knot_raddr;
	logic [COEF_AW-1:0]       coef_raddr;
	logic [DATA_W-1:0]        knot_rdata, coef_rdata;

	assign in_stall = (state_q != F_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (knot_count < CNT_W'(2)) begin
			n_c = CNT_W'(2);
		end else if (knot_count > CNT_W'(MAX_KNOTS)) begin
			n_c = CNT_W'(MAX_KNOTS);
		end else begin
			n_c = knot_count;
		end
		hi0   = KNOT_AW'(n_c - CNT_W'(1));
		mid0  = hi0 >> 1;
		more0 = hi0 > KNOT_AW'(1);

		// knot data arriving now belongs to mid_q
		knot_gt = $signed(knot_rdata) > x_q;
		lo_n    = knot_gt ? lo_q : mid_q;
		hi_n    = knot_gt ? mid_q : hi_q;
		mid_n   = KNOT_AW'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
		diff_n  = hi_n - lo_n;
		more_n  = diff_n > KNOT_AW'(1);

		knot_raddr = (state_q == F_IDLE) ? mid0 : mid_n;
		coef_raddr = {seg_q, fcnt_q[1:0]};

		knot_we = accept && (cmd == CMD_LOAD_KNOT) && (32'(index) < 32'(MAX_KNOTS));
		coef_we = accept && (cmd == CMD_LOAD_COEF) && (32'(index) < 32'(COEF_DEPTH));

		q_push = (state_q == F_PUSH) && !q_full;
		q_job  = job_q;
	end

	csev_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_knot_ram (
		.clk   (clk),
		.we    (knot_we),
		.waddr (KNOT_AW'(index)),
		.wdata (value),
		.raddr (knot_raddr),
		.rdata (knot_rdata)
	);

	csev_ram #(.WIDTH(DATA_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (COEF_AW'(index)),
		.wdata (value),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fcnt_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && cmd == CMD_EVAL) begin
						x_q       <= value;
						job_q.x   <= value;
						lo_q      <= '0;
						hi_q      <= hi0;
						mid_q     <= mid0;
						fcnt_q    <= '0;
						seg_q     <= '0;
						job_q.seg <= '0;
						state_q   <= more0 ? F_SEARCH : F_FETCH;
					end
				end
				F_SEARCH: begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_n;
					if (!more_n) begin
						seg_q     <= lo_n;
						job_q.seg <= lo_n;
						state_q   <= F_FETCH;
					end
				end
				F_FETCH: begin
					// reads issued at counts 0..3, each word lands at the following count
					unique case (fcnt_q)
						3'd1: job_q.d <= coef_rdata;
						3'd2: job_q.c <= coef_rdata;
						3'd3: job_q.b <= coef_rdata;
						3'd4: job_q.a <= coef_rdata;
						default: ;
					endcase
					fcnt_q <= fcnt_q + 3'd1;
					if (fcnt_q == 3'd4) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/csev_queue.sv */
// small fifo of evaluation jobs between front and back
`default_nettype none
module csev_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  csev_pkg::job_t push_job,
	input  logic           pop,
	output csev_pkg::job_t head,
	output logic           empty,
	output logic           full
);
	import csev_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		nxt = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= nxt(wp_q);
			end
			if (pop && !empty) begin
				rp_q <= nxt(rp_q);
			end
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

/* rtl/csev_back.sv */
// back end: limb-serial horner evaluation, rounding, saturation and result register
`default_nettype none
module csev_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  csev_pkg::job_t              q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [csev_pkg::DATA_W-1:0] y_value,
	output logic signed [csev_pkg::DATA_W-1:0] slope,
	output logic signed [csev_pkg::DATA_W-1:0] curvature,
	output logic [csev_pkg::SEG_W-1:0]  segment,
	output logic                        saturated
);
	import csev_pkg::*;

	localparam int LIMB_SH = $clog2(LIMB_W);

	typedef enum logic [1:0] {B_IDLE, B_MUL, B_FIN, B_OUT} bstate_t;
	// value: (a*x + b)*x + c, *x + d ; slope: (3a*x + 2b)*x + c ; curvature: 6a*x + 2b
	typedef enum logic [2:0] {
		ST_VAL_A, ST_VAL_B, ST_VAL_Y, ST_DER_A, ST_DER_Y, ST_CURV
	} step_t;

	bstate_t                  state_q;
	step_t                    step_q;
	logic [1:0]               limb_q;
	job_t                     job_q;
	logic signed [ACC_W-1:0]  m_q, acc_q;
	logic signed [DATA_W-1:0] y_q, dy_q, ddy_q;
	logic                     sat_q, out_valid_q;

	step_t                    step_nx;
	logic [1:0]               last;
	logic [LIMB_W-1:0]        limb_bits;
	logic signed [LIMB_W:0]   op;
	logic signed [LIMB_W+DATA_W:0] pp;
	logic signed [ACC_W-1:0]  pp_sh, a3;
	logic [DATA_W:0]          r_y, r_dy, r_dd;

	function automatic logic signed [ACC_W-1:0] sx(input logic signed [DATA_W-1:0] v);
		sx = ACC_W'(v);
	endfunction

	function automatic logic signed [ACC_W-1:0] addend(input step_t s, input job_t j);
		unique case (s)
			ST_VAL_A:           addend = sx(j.b) <<< FRAC_BITS;
			ST_DER_A, ST_CURV:  addend = sx(j.b) <<< (FRAC_BITS + 1);
			ST_VAL_B, ST_DER_Y: addend = sx(j.c) <<< (2 * FRAC_BITS);
			ST_VAL_Y:           addend = sx(j.d) <<< (3 * FRAC_BITS);
			default:            addend = '0;
		endcase
	endfunction

	// index of the top (signed) limb of the multiplicand in each step
	function automatic logic [1:0] last_limb(input step_t s);
		unique case (s)
			ST_VAL_A:                     last_limb = 2'd0;
			ST_DER_A, ST_CURV:            last_limb = 2'd1;
			ST_VAL_B, ST_VAL_Y, ST_DER_Y: last_limb = 2'd2;
			default:                      last_limb = 2'd2;
		endcase
	endfunction

	// round half up, shift right by n, clip to 32 bits; msb flags a clip
	function automatic logic [DATA_W:0] rsat(input logic signed [ACC_W-1:0] w,
			input int unsigned n);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-1:0] s;
		t = w + (ACC_W'(1) << (n - 1));
		s = t >>> n;
		if ((&s[ACC_W-1:DATA_W-1]) || !(|s[ACC_W-1:DATA_W-1])) begin
			rsat = {1'b0, s[DATA_W-1:0]};
		end else if (s[ACC_W-1]) begin
			rsat = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			rsat = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

	always_comb begin
		step_nx   = step_t'(step_q + 3'd1);
		last      = last_limb(step_q);
		limb_bits = m_q[{limb_q, {LIMB_SH{1'b0}}} +: LIMB_W];
		op        = (limb_q == last) ? {limb_bits[LIMB_W-1], limb_bits} : {1'b0, limb_bits};
		pp        = op * job_q.x;
		pp_sh     = ACC_W'(pp) <<< {limb_q, {LIMB_SH{1'b0}}};
		a3        = (sx(job_q.a) <<< 1) + sx(job_q.a);
		r_y       = rsat(acc_q, 3 * FRAC_BITS);
		r_dy      = rsat(acc_q, 2 * FRAC_BITS);
		r_dd      = rsat(acc_q, FRAC_BITS);
		q_pop     = (state_q == B_IDLE) && !q_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= ST_VAL_A;
			limb_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						job_q   <= q_head;
						m_q     <= sx(q_head.a);
						acc_q   <= addend(ST_VAL_A, q_head);
						step_q  <= ST_VAL_A;
						limb_q  <= '0;
						sat_q   <= 1'b0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					acc_q <= acc_q + pp_sh;
					if (limb_q == last) begin
						state_q <= B_FIN;
					end else begin
						limb_q <= limb_q + 2'd1;
					end
				end
				B_FIN: begin
					unique case (step_q)
						ST_VAL_A, ST_VAL_B, ST_DER_A: m_q <= acc_q;
						ST_VAL_Y: begin
							y_q   <= r_y[DATA_W-1:0];
							sat_q <= sat_q | r_y[DATA_W];
							m_q   <= a3;
						end
						ST_DER_Y: begin
							dy_q  <= r_dy[DATA_W-1:0];
							sat_q <= sat_q | r_dy[DATA_W];
							m_q   <= a3 <<< 1;
						end
						ST_CURV: begin
							ddy_q <= r_dd[DATA_W-1:0];
							sat_q <= sat_q | r_dd[DATA_W];
						end
						default: ;
					endcase
					if (step_q == ST_CURV) begin
						out_valid_q <= 1'b1;
						state_q     <= B_OUT;
					end else begin
						acc_q   <= addend(step_nx, job_q);
						step_q  <= step_nx;
						limb_q  <= '0;
						state_q <= B_MUL;
					end
				end
				B_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign y_value   = y_q;
	assign slope     = dy_q;
	assign curvature = ddy_q;
	assign segment   = SEG_W'(job_q.seg);
	assign saturated = sat_q;
endmodule
`default_nettype wire

/* rtl/cubic_spline_evaluator.sv */
// top level of the piecewise cubic spline evaluator
// Load commands (knot or coefficient) leave the front end idle and give no result. An
// evaluate command occupies the front end for its whole run: one knot memory read per
// binary-search step, then four coefficient reads and a push into a two-entry job queue,
// held while the queue is full. The back end pops the job, then for each of its six Horner
// terms walks the 32-bit limbs of the multiplicand through its single 33x32 multiplier and
// finishes the term, rounding the value, slope and curvature terms, and holds the result
// while its output is stalled. It takes the next job only after presenting the result, while
// the front searches for the next query. Knot and coefficient memories are not cleared at
// reset; every entry a query can reach must be loaded first. knot_count is clamped to [2, 64]
// for the search; write it only while the block is idle.
`default_nettype none
module cubic_spline_evaluator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [csev_pkg::IDX_W-1:0]  index,
	input  logic signed [csev_pkg::DATA_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [csev_pkg::DATA_W-1:0] y_value,
	output logic signed [csev_pkg::DATA_W-1:0] slope,
	output logic signed [csev_pkg::DATA_W-1:0] curvature,
	output logic [csev_pkg::SEG_W-1:0]  segment,
	output logic                        saturated,
	input  logic                        cfg_we,
	input  logic [csev_pkg::CNT_W-1:0]  cfg_wdata
);
	import csev_pkg::*;

	logic [CNT_W-1:0] knot_count_q;
	logic             q_push, q_pop, q_empty, q_full;
	job_t             push_job, head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= CNT_W'(2);
		end else if (cfg_we) begin
			knot_count_q <= cfg_wdata;
		end
	end

	csev_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.knot_count (knot_count_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	csev_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	csev_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.y_value   (y_value),
		.slope     (slope),
		.curvature (curvature),
		.segment   (segment),
		.saturated (saturated)
	);
endmodule
`default_nettype wire

/* rtl/csev_checker.sv */
// port-level checks of the spline evaluator and their bind to the top level
`default_nettype none
`include "cubic_spline_evaluator_defines.svh"
module csev_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [1:0]                  cmd,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [csev_pkg::DATA_W-1:0] y_value,
	input logic [csev_pkg::DATA_W-1:0] slope,
	input logic [csev_pkg::DATA_W-1:0] curvature,
	input logic [csev_pkg::SEG_W-1:0]  segment,
	input logic                        saturated
);
	import csev_pkg::*;

	// a stalled result beat holds
	`CSEV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(y_value) && $stable(slope) && $stable(curvature) && $stable(segment) && $stable(saturated))
	// the search never lands past the next-to-last knot
	`CSEV_ASSERT_NOW(a_seg_range, out_valid, segment != {SEG_W{1'b1}})
	// table loads leave the front free for the next beat
	`CSEV_ASSERT_NEXT(a_load_free, in_valid && !in_stall && (cmd == CMD_LOAD_KNOT || cmd == CMD_LOAD_COEF), !in_stall)
	// an evaluate keeps the front busy with its search and coefficient fetch
	`CSEV_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && cmd == CMD_EVAL, in_stall)
endmodule

bind cubic_spline_evaluator csev_checker u_csev_checker (.*);
`default_nettype wire
